// ===== hw/rtl/utxq_pkg.sv =====
// Shared types and constants for the UART transmit serializer with queue.
`default_nettype none
package utxq_pkg;

   // Item kinds carried on the request tuser bit
   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_PUSH = 1'b1;

   localparam int  BYTE_W      = 8;
   localparam int  CNT_W       = 5;
   localparam logic [CNT_W-1:0] IDLE_COUNT = 5'd20;
   localparam int  FRAME_W     = 10;
   localparam int  RSP_TDATA_W = 8;

   typedef struct packed {
      logic              is_push;
      logic [BYTE_W-1:0] data_byte;
   } item_type;

   // Last member sits in bit 0, so line_pos is the lowest bit
   typedef struct packed {
      logic busy_res;
      logic accepted;
      logic bit_driven;
      logic line_neg;
      logic line_pos;
   } result_type;

endpackage
`default_nettype wire

// ===== hw/rtl/utxq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module utxq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

// ===== hw/rtl/utxq_front.sv =====
// Front end: takes request beats, tags them tick or push, holds them in a two-entry queue.
`default_nettype none
module utxq_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   output logic                         in_ready,
   input  wire logic                    in_cmd,
   input  wire logic [utxq_pkg::BYTE_W-1:0] in_byte,
   output logic                         out_valid,
   input  wire logic                    out_take,
   output utxq_pkg::item_type           out_item
);
   import utxq_pkg::*;

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;
   item_type   new_item;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_item  = entry_ff[rd_ptr_ff];

   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_take;

   always_comb begin
      new_item.is_push   = (in_cmd == CMD_PUSH);
      new_item.data_byte = in_byte;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/utxq_back.sv =====
// Back end: transmit ring, 8N1 frame serializer and the result register.
`default_nettype none
module utxq_back #(
   parameter int QUEUE_DEPTH = 8
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                item_valid,
   output logic                     item_take,
   input  utxq_pkg::item_type       item,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output utxq_pkg::result_type     rsp_result
);
   import utxq_pkg::*;

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

   logic [IDX_W-1:0]   wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic               level_ff, level_in;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         result_ff, result_in;
   logic               fwd_hit_ff, fwd_hit_in;
   logic [BYTE_W-1:0]  fwd_data_ff;

   logic [IDX_W-1:0]   wr_next, rd_next;
   logic               ring_wr;
   logic [BYTE_W-1:0]  ram_q, head_byte;
   logic               active, driven, accepted;
   logic [CNT_W-1:0]   cnt_work;

   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
      return (idx == LAST_IDX) ? '0 : idx + IDX_W'(1);
   endfunction

   assign item_take  = item_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = result_ff;

   assign wr_next = ring_next(wr_idx_ff);
   assign rd_next = ring_next(rd_idx_ff);

   // RAM reads the head entry every cycle; a write to that entry in the same cycle
   // is forwarded, since the read returns the old contents
   assign head_byte = fwd_hit_ff ? fwd_data_ff : ram_q;

   always_comb begin
      wr_idx_in    = wr_idx_ff;
      rd_idx_in    = rd_idx_ff;
      cnt_in       = cnt_ff;
      frame_in     = frame_ff;
      level_in     = level_ff;
      ring_wr      = 1'b0;
      accepted     = 1'b0;
      driven       = 1'b0;
      active       = 1'b1;
      cnt_work     = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      result_in    = result_ff;

      if (item_take) begin
         if (item.is_push) begin
            if (wr_next != rd_idx_ff) begin
               ring_wr   = 1'b1;
               wr_idx_in = wr_next;
               accepted  = 1'b1;
            end
         end else begin
            if (cnt_ff >= IDLE_COUNT) begin
               if (wr_idx_ff == rd_idx_ff) begin
                  active = 1'b0;
               end else begin
                  frame_in  = {1'b1, head_byte, 1'b0};
                  rd_idx_in = rd_next;
                  cnt_work  = '0;
               end
            end
            if (active) begin
               // odd half-bit counts put the next frame bit on the line
               if (cnt_work[0]) begin
                  level_in = frame_in[0];
                  frame_in = {1'b1, frame_in[FRAME_W-1:1]};
                  driven   = 1'b1;
               end
               cnt_in = cnt_work + CNT_W'(1);
            end
         end
         rsp_valid_in         = 1'b1;
         result_in.line_pos   = level_in;
         result_in.line_neg   = ~level_in;
         result_in.bit_driven = driven;
         result_in.accepted   = accepted;
         result_in.busy_res   = (cnt_in < IDLE_COUNT) || (wr_idx_in != rd_idx_in);
      end

      fwd_hit_in = ring_wr && (wr_idx_ff == rd_idx_in);
   end

   utxq_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_wr),
      .wr_addr (wr_idx_ff),
      .wr_data (item.data_byte),
      .rd_addr (rd_idx_in),
      .rd_data (ram_q)
   );

   always_ff @(posedge clock) begin
      result_ff   <= result_in;
      frame_ff    <= frame_in;
      fwd_data_ff <= item.data_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff    <= '0;
         rd_idx_ff    <= '0;
         cnt_ff       <= IDLE_COUNT;
         level_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
         fwd_hit_ff   <= 1'b0;
      end else begin
         wr_idx_ff    <= wr_idx_in;
         rd_idx_ff    <= rd_idx_in;
         cnt_ff       <= cnt_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
         fwd_hit_ff   <= fwd_hit_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/uart_tx_serializer_with_queue.sv =====
// Top level: UART 8N1 transmitter with transmit ring, differential line outputs.
//
//   channel | dir | tdata                          | tuser
//   req_    | in  | data_byte[7:0]                 | cmd (0 tick, 1 push)
//   rsp_    | out | line_pos, line_neg, bit_driven, | -
//           |     | accepted, busy_res, 3 zero bits |
//
// One beat per cycle in and out while rsp_tready is held high. A request passes through
// the front queue entry and then the result register on its way to its response.
// Reset (synchronous) empties the ring and both queues, sets the line to idle mark.
// A stalled response holds the back end; the two-entry front queue absorbs requests
// until it fills, then req_tready drops.
`default_nettype none
module uart_tx_serializer_with_queue #(
   parameter int QUEUE_DEPTH = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tuser,   // [0] cmd
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata    // [0] line_pos [1] line_neg [2] bit_driven
                                         // [3] accepted [4] busy_res [7:5] zero
);
   import utxq_pkg::*;

   logic       item_valid;
   logic       item_take;
   item_type   item;
   result_type result;

   utxq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_cmd    (req_tuser),
      .in_byte   (req_tdata),
      .out_valid (item_valid),
      .out_take  (item_take),
      .out_item  (item)
   );

   utxq_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_take  (item_take),
      .item       (item),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (result)
   );

   assign rsp_tdata = {(RSP_TDATA_W - $bits(result_type))'(0), result};

endmodule
`default_nettype wire
